// File: hw/rtl/gnp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gnp_pkg;

   localparam int FIELD_WIDTH = 24;
   localparam int ID_WIDTH    = 6;
   localparam int TOTAL_WIDTH = 7;
   localparam int LEN_WIDTH   = 26;

   localparam logic [LEN_WIDTH-1:0] LEN_MAX = {LEN_WIDTH{1'b1}};

   typedef enum logic [1:0] {
      ACT_ADD  = 2'd0,
      ACT_POP  = 2'd1,
      ACT_LINK = 2'd2,
      ACT_PICK = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_BAD   = 2'd3
   } status_type;

endpackage

`default_nettype wire

// File: hw/rtl/graph_node_table_nearest_pick.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir   Handshake              Payload
// req       in    req_valid/req_ready    action, pos_x, pos_y, pos_z, first_id, second_id
// rsp       out   rsp_valid/rsp_ready    picked_index, node_total, link_length, status
//
// One item at a time; req_ready is high only while the sequencer is idle.
// Add: writes the position and clears its link count. Pick: runs each stored node through the distance unit.
// Link: computes the squared distance, then the length with the bit-serial square root.
// Pop: for each node, rescans its stored links and drops those that point at the last node.
// Synchronous reset clears control state only; a stalled rsp beat holds.

module graph_node_table_nearest_pick #(
   parameter int MAX_NODES  = 64,
   parameter int MAX_LINKS  = 8,
   parameter int COORD_BITS = 24
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire gnp_pkg::action_type                    req_action,
   input  wire logic signed [gnp_pkg::FIELD_WIDTH-1:0] req_pos_x,
   input  wire logic signed [gnp_pkg::FIELD_WIDTH-1:0] req_pos_y,
   input  wire logic signed [gnp_pkg::FIELD_WIDTH-1:0] req_pos_z,
   input  wire logic [gnp_pkg::ID_WIDTH-1:0]           req_first_id,
   input  wire logic [gnp_pkg::ID_WIDTH-1:0]           req_second_id,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic [gnp_pkg::ID_WIDTH-1:0]                rsp_picked_index,
   output logic [gnp_pkg::TOTAL_WIDTH-1:0]             rsp_node_total,
   output logic [gnp_pkg::LEN_WIDTH-1:0]               rsp_link_length,
   output gnp_pkg::status_type                         rsp_status
);

   import gnp_pkg::*;

   localparam int NW  = $clog2(MAX_NODES);
   localparam int CW  = $clog2(MAX_NODES + 1);
   localparam int LCW = $clog2(MAX_LINKS + 1);
   localparam int LAW = $clog2(MAX_NODES * MAX_LINKS);
   localparam int SW  = 2 * COORD_BITS + 2;
   localparam int RW  = COORD_BITS + 1;
   localparam int IDW = (CW > ID_WIDTH) ? CW : ID_WIDTH;

   typedef enum logic [4:0] {
      S_IDLE, S_ADD, S_POP_CNT, S_POP_SCAN, S_LNK_CNTA, S_LNK_CNTB, S_LNK_CHECK,
      S_LNK_POSA, S_LNK_DIST0, S_LNK_DIST, S_LNK_SQRT, S_LNK_WRA, S_LNK_WRB,
      S_PK_RD, S_PK_START, S_PK_DIST, S_DONE
   } state_type;

   state_type             state_ff, state_in;
   logic [COORD_BITS-1:0] q_x_ff, q_x_in, q_y_ff, q_y_in, q_z_ff, q_z_in;
   logic [ID_WIDTH-1:0]   a_ff, a_in, b_ff, b_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [NW-1:0]         i_ff, i_in, last_ff, last_in;
   logic [LCW-1:0]        j_ff, j_in, k_ff, k_in;
   logic                  dv_ff, dv_in;
   logic [LCW-1:0]        cnt_a_ff, cnt_a_in, cnt_b_ff, cnt_b_in;
   logic [SW-1:0]         best_ff, best_in;
   logic [ID_WIDTH-1:0]   res_picked_ff, res_picked_in;
   logic [LEN_WIDTH-1:0]  res_len_ff, res_len_in;
   status_type            res_status_ff, res_status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ID_WIDTH-1:0]   rsp_picked_ff, rsp_picked_in;
   logic [TOTAL_WIDTH-1:0] rsp_total_ff, rsp_total_in;
   logic [LEN_WIDTH-1:0]  rsp_len_ff, rsp_len_in;
   status_type            rsp_status_ff, rsp_status_in;

   logic [COORD_BITS-1:0] pos_x_mem [MAX_NODES];
   logic [COORD_BITS-1:0] pos_y_mem [MAX_NODES];
   logic [COORD_BITS-1:0] pos_z_mem [MAX_NODES];
   logic [COORD_BITS-1:0] pos_x_rd_ff, pos_y_rd_ff, pos_z_rd_ff;
   logic                  pos_we, pos_re;
   logic [NW-1:0]         pos_waddr, pos_raddr;

   logic [LCW-1:0]        cnt_mem [MAX_NODES];
   logic [LCW-1:0]        cnt_rd_ff;
   logic                  cnt_we, cnt_re;
   logic [NW-1:0]         cnt_waddr, cnt_raddr;
   logic [LCW-1:0]        cnt_wdata;

   logic [NW-1:0]         lnk_tgt_mem [MAX_NODES * MAX_LINKS];
   logic [LEN_WIDTH-1:0]  lnk_wgt_mem [MAX_NODES * MAX_LINKS];
   logic [NW-1:0]         lnk_tgt_rd_ff;
   logic [LEN_WIDTH-1:0]  lnk_wgt_rd_ff;
   logic                  lnk_we, lnk_re;
   logic [LAW-1:0]        lnk_waddr, lnk_raddr;
   logic [NW-1:0]         lnk_wtgt;
   logic [LEN_WIDTH-1:0]  lnk_wwgt;

   logic                  dist_start, dist_done;
   logic [SW-1:0]         dist_sum;
   logic                  sqrt_start, sqrt_done;
   logic [RW-1:0]         sqrt_root;
   logic                  scan_issue;
   logic                  room;
   logic                  len_sat;

   function automatic logic [LAW-1:0] link_addr(input logic [NW-1:0] node,
                                                input logic [LCW-1:0] slot);
      return LAW'(32'(node) * 32'(MAX_LINKS) + 32'(slot));
   endfunction

   gnp_dist #(.COORD_BITS(COORD_BITS)) u_dist (
      .clock   (clock),
      .reset   (reset),
      .start   (dist_start),
      .base_x  (pos_x_rd_ff),
      .base_y  (pos_y_rd_ff),
      .base_z  (pos_z_rd_ff),
      .query_x (q_x_ff),
      .query_y (q_y_ff),
      .query_z (q_z_ff),
      .done    (dist_done),
      .sum     (dist_sum)
   );

   gnp_isqrt #(.COORD_BITS(COORD_BITS)) u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_start),
      .value (dist_sum),
      .done  (sqrt_done),
      .root  (sqrt_root)
   );

   assign scan_issue = j_ff < cnt_rd_ff;
   assign len_sat    = (70'(dist_sum) >= (70'd1 << 52)) || (40'(sqrt_root) > 40'(LEN_MAX));

   always_comb begin
      if (a_ff == b_ff) begin
         room = (LCW + 2)'(cnt_a_ff) + (LCW + 2)'(2) <= (LCW + 2)'(MAX_LINKS);
      end else begin
         room = ((LCW + 1)'(cnt_a_ff) < (LCW + 1)'(MAX_LINKS)) &&
                ((LCW + 1)'(cnt_rd_ff) < (LCW + 1)'(MAX_LINKS));
      end
   end

   always_comb begin
      state_in      = state_ff;
      q_x_in        = q_x_ff;
      q_y_in        = q_y_ff;
      q_z_in        = q_z_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      count_in      = count_ff;
      i_in          = i_ff;
      last_in       = last_ff;
      j_in          = j_ff;
      k_in          = k_ff;
      dv_in         = 1'b0;
      cnt_a_in      = cnt_a_ff;
      cnt_b_in      = cnt_b_ff;
      best_in       = best_ff;
      res_picked_in = res_picked_ff;
      res_len_in    = res_len_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_picked_in = rsp_picked_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_status_in = rsp_status_ff;
      pos_we        = 1'b0;
      pos_re        = 1'b0;
      pos_waddr     = NW'(count_ff);
      pos_raddr     = i_ff;
      cnt_we        = 1'b0;
      cnt_re        = 1'b0;
      cnt_waddr     = i_ff;
      cnt_raddr     = i_ff;
      cnt_wdata     = k_ff;
      lnk_we        = 1'b0;
      lnk_re        = 1'b0;
      lnk_waddr     = link_addr(i_ff, k_ff);
      lnk_raddr     = link_addr(i_ff, j_ff);
      lnk_wtgt      = lnk_tgt_rd_ff;
      lnk_wwgt      = lnk_wgt_rd_ff;
      dist_start    = 1'b0;
      sqrt_start    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               q_x_in        = COORD_BITS'($unsigned(req_pos_x));
               q_y_in        = COORD_BITS'($unsigned(req_pos_y));
               q_z_in        = COORD_BITS'($unsigned(req_pos_z));
               a_in          = req_first_id;
               b_in          = req_second_id;
               i_in          = '0;
               last_in       = NW'(count_ff - CW'(1));
               res_picked_in = '0;
               res_len_in    = '0;
               res_status_in = ST_OK;
               unique case (req_action)
                  ACT_ADD: begin
                     if (count_ff == CW'(MAX_NODES)) begin
                        res_status_in = ST_FULL;
                        state_in      = S_DONE;
                     end else begin
                        state_in = S_ADD;
                     end
                  end
                  ACT_POP: begin
                     if (count_ff == '0) begin
                        res_status_in = ST_EMPTY;
                        state_in      = S_DONE;
                     end else begin
                        state_in = S_POP_CNT;
                     end
                  end
                  ACT_LINK: begin
                     if ((IDW'(req_first_id) >= IDW'(count_ff)) ||
                         (IDW'(req_second_id) >= IDW'(count_ff))) begin
                        res_status_in = ST_BAD;
                        state_in      = S_DONE;
                     end else begin
                        state_in = S_LNK_CNTA;
                     end
                  end
                  ACT_PICK: begin
                     if (count_ff == '0) begin
                        res_status_in = ST_EMPTY;
                        state_in      = S_DONE;
                     end else begin
                        state_in = S_PK_RD;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_ADD: begin
            pos_we    = 1'b1;
            cnt_we    = 1'b1;
            cnt_waddr = NW'(count_ff);
            cnt_wdata = '0;
            count_in  = count_ff + CW'(1);
            state_in  = S_DONE;
         end
         S_POP_CNT: begin
            cnt_re   = 1'b1;
            j_in     = '0;
            k_in     = '0;
            state_in = S_POP_SCAN;
         end
         S_POP_SCAN: begin
            if (scan_issue) begin
               lnk_re = 1'b1;
               j_in   = j_ff + LCW'(1);
            end
            dv_in = scan_issue;
            if (dv_ff && (lnk_tgt_rd_ff != last_ff)) begin
               lnk_we = 1'b1;
               k_in   = k_ff + LCW'(1);
            end
            if (!scan_issue && !dv_ff) begin
               cnt_we = 1'b1;
               if (i_ff == last_ff) begin
                  count_in = CW'(last_ff);
                  state_in = S_DONE;
               end else begin
                  i_in     = i_ff + NW'(1);
                  state_in = S_POP_CNT;
               end
            end
         end
         S_LNK_CNTA: begin
            cnt_re    = 1'b1;
            cnt_raddr = NW'(a_ff);
            state_in  = S_LNK_CNTB;
         end
         S_LNK_CNTB: begin
            cnt_a_in  = cnt_rd_ff;
            cnt_re    = 1'b1;
            cnt_raddr = NW'(b_ff);
            state_in  = S_LNK_CHECK;
         end
         S_LNK_CHECK: begin
            cnt_b_in = (a_ff == b_ff) ? cnt_a_ff + LCW'(1) : cnt_rd_ff;
            if (!room) begin
               res_status_in = ST_BAD;
               state_in      = S_DONE;
            end else begin
               pos_re    = 1'b1;
               pos_raddr = NW'(b_ff);
               state_in  = S_LNK_POSA;
            end
         end
         S_LNK_POSA: begin
            q_x_in    = pos_x_rd_ff;
            q_y_in    = pos_y_rd_ff;
            q_z_in    = pos_z_rd_ff;
            pos_re    = 1'b1;
            pos_raddr = NW'(a_ff);
            state_in  = S_LNK_DIST0;
         end
         S_LNK_DIST0: begin
            dist_start = 1'b1;
            state_in   = S_LNK_DIST;
         end
         S_LNK_DIST: begin
            if (dist_done) begin
               sqrt_start = 1'b1;
               state_in   = S_LNK_SQRT;
            end
         end
         S_LNK_SQRT: begin
            if (sqrt_done) begin
               res_len_in = len_sat ? LEN_MAX : LEN_WIDTH'(sqrt_root);
               state_in   = S_LNK_WRA;
            end
         end
         S_LNK_WRA: begin
            lnk_we    = 1'b1;
            lnk_waddr = link_addr(NW'(a_ff), cnt_a_ff);
            lnk_wtgt  = NW'(b_ff);
            lnk_wwgt  = res_len_ff;
            cnt_we    = 1'b1;
            cnt_waddr = NW'(a_ff);
            cnt_wdata = cnt_a_ff + LCW'(1);
            state_in  = S_LNK_WRB;
         end
         S_LNK_WRB: begin
            lnk_we    = 1'b1;
            lnk_waddr = link_addr(NW'(b_ff), cnt_b_ff);
            lnk_wtgt  = NW'(a_ff);
            lnk_wwgt  = res_len_ff;
            cnt_we    = 1'b1;
            cnt_waddr = NW'(b_ff);
            cnt_wdata = cnt_b_ff + LCW'(1);
            state_in  = S_DONE;
         end
         S_PK_RD: begin
            pos_re   = 1'b1;
            state_in = S_PK_START;
         end
         S_PK_START: begin
            dist_start = 1'b1;
            state_in   = S_PK_DIST;
         end
         S_PK_DIST: begin
            if (dist_done) begin
               if ((i_ff == '0) || (dist_sum < best_ff)) begin
                  best_in       = dist_sum;
                  res_picked_in = ID_WIDTH'(i_ff);
               end
               if (i_ff == last_ff) begin
                  state_in = S_DONE;
               end else begin
                  i_in     = i_ff + NW'(1);
                  state_in = S_PK_RD;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_picked_in = res_picked_ff;
               rsp_total_in  = TOTAL_WIDTH'(count_ff);
               rsp_len_in    = res_len_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      q_x_ff        <= q_x_in;
      q_y_ff        <= q_y_in;
      q_z_ff        <= q_z_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      i_ff          <= i_in;
      last_ff       <= last_in;
      j_ff          <= j_in;
      k_ff          <= k_in;
      cnt_a_ff      <= cnt_a_in;
      cnt_b_ff      <= cnt_b_in;
      best_ff       <= best_in;
      res_picked_ff <= res_picked_in;
      res_len_ff    <= res_len_in;
      res_status_ff <= res_status_in;
      rsp_picked_ff <= rsp_picked_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (pos_we) begin
         pos_x_mem[pos_waddr] <= q_x_ff;
         pos_y_mem[pos_waddr] <= q_y_ff;
         pos_z_mem[pos_waddr] <= q_z_ff;
      end
      if (pos_re) begin
         pos_x_rd_ff <= pos_x_mem[pos_raddr];
         pos_y_rd_ff <= pos_y_mem[pos_raddr];
         pos_z_rd_ff <= pos_z_mem[pos_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_waddr] <= cnt_wdata;
      end
      if (cnt_re) begin
         cnt_rd_ff <= cnt_mem[cnt_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (lnk_we) begin
         lnk_tgt_mem[lnk_waddr] <= lnk_wtgt;
         lnk_wgt_mem[lnk_waddr] <= lnk_wwgt;
      end
      if (lnk_re) begin
         lnk_tgt_rd_ff <= lnk_tgt_mem[lnk_raddr];
         lnk_wgt_rd_ff <= lnk_wgt_mem[lnk_raddr];
      end
   end

   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_picked_index = rsp_picked_ff;
   assign rsp_node_total   = rsp_total_ff;
   assign rsp_link_length  = rsp_len_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

`default_nettype wire

// File: hw/rtl/gnp_dist.sv
`timescale 1ns / 1ps
`default_nettype none

module gnp_dist #(
   parameter int COORD_BITS = 24
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [COORD_BITS-1:0]     base_x,
   input  wire logic [COORD_BITS-1:0]     base_y,
   input  wire logic [COORD_BITS-1:0]     base_z,
   input  wire logic [COORD_BITS-1:0]     query_x,
   input  wire logic [COORD_BITS-1:0]     query_y,
   input  wire logic [COORD_BITS-1:0]     query_z,
   output logic                           done,
   output logic [2*COORD_BITS+1:0]        sum
);

   localparam int SW = 2 * COORD_BITS + 2;
   localparam int PW = 2 * COORD_BITS;

   logic [2:0]            step_ff, step_in;
   logic                  done_ff, done_in;
   logic [COORD_BITS-1:0] mag_x_ff, mag_x_in;
   logic [COORD_BITS-1:0] mag_y_ff, mag_y_in;
   logic [COORD_BITS-1:0] mag_z_ff, mag_z_in;
   logic [PW-1:0]         sq_ff, sq_in;
   logic [SW-1:0]         acc_ff, acc_in;
   logic [COORD_BITS-1:0] mult_op;

   function automatic logic [COORD_BITS-1:0] abs_diff(input logic [COORD_BITS-1:0] a,
                                                      input logic [COORD_BITS-1:0] b);
      logic signed [COORD_BITS:0] d;
      logic [COORD_BITS:0]        n;
      d = $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
      n = -d;
      return d[COORD_BITS] ? n[COORD_BITS-1:0] : d[COORD_BITS-1:0];
   endfunction

   always_comb begin
      unique case (step_ff)
         3'd1:    mult_op = mag_x_ff;
         3'd2:    mult_op = mag_y_ff;
         default: mult_op = mag_z_ff;
      endcase
   end

   always_comb begin
      step_in  = step_ff;
      done_in  = 1'b0;
      mag_x_in = mag_x_ff;
      mag_y_in = mag_y_ff;
      mag_z_in = mag_z_ff;
      sq_in    = sq_ff;
      acc_in   = acc_ff;
      unique case (step_ff)
         3'd0: begin
            if (start) begin
               mag_x_in = abs_diff(base_x, query_x);
               mag_y_in = abs_diff(base_y, query_y);
               mag_z_in = abs_diff(base_z, query_z);
               step_in  = 3'd1;
            end
         end
         3'd1: begin
            sq_in   = PW'(mult_op) * PW'(mult_op);
            step_in = 3'd2;
         end
         3'd2: begin
            sq_in   = PW'(mult_op) * PW'(mult_op);
            acc_in  = SW'(sq_ff);
            step_in = 3'd3;
         end
         3'd3: begin
            sq_in   = PW'(mult_op) * PW'(mult_op);
            acc_in  = acc_ff + SW'(sq_ff);
            step_in = 3'd4;
         end
         3'd4: begin
            acc_in  = acc_ff + SW'(sq_ff);
            done_in = 1'b1;
            step_in = 3'd0;
         end
         default: step_in = 3'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 3'd0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
      mag_x_ff <= mag_x_in;
      mag_y_ff <= mag_y_in;
      mag_z_ff <= mag_z_in;
      sq_ff    <= sq_in;
      acc_ff   <= acc_in;
   end

   assign done = done_ff;
   assign sum  = acc_ff;

endmodule

`default_nettype wire

// File: hw/rtl/gnp_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none

module gnp_isqrt #(
   parameter int COORD_BITS = 24
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [2*COORD_BITS+1:0]   value,
   output logic                           done,
   output logic [COORD_BITS:0]            root
);

   localparam int SW = 2 * COORD_BITS + 2;
   localparam int N  = SW / 2;
   localparam int IW = $clog2(N + 1);

   logic [SW-1:0] val_ff, val_in;
   logic [N+1:0]  rem_ff, rem_in;
   logic [N-1:0]  root_ff, root_in;
   logic [IW-1:0] iter_ff, iter_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [N+1:0]  rem_sh;
   logic [N+1:0]  trial;

   assign rem_sh = {rem_ff[N-1:0], val_ff[SW-1 -: 2]};
   assign trial  = {root_ff, 2'b01};

   always_comb begin
      val_in  = val_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      iter_in = iter_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (busy_ff) begin
         val_in = {val_ff[SW-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[N-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[N-2:0], 1'b0};
         end
         iter_in = iter_ff - IW'(1);
         if (iter_ff == IW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         val_in  = value;
         rem_in  = '0;
         root_in = '0;
         iter_in = IW'(N);
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      iter_ff <= iter_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

`default_nettype wire
